### design/gltm_pkg.sv
// ----------------------------------------------------------------------------
// gltm_pkg
// Shared widths, reset values and register codes of the gossip load table
// merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package gltm_pkg;

    // default sizes of the table and of one load value
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int LOAD_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int ID_W  = 6;
    localparam int HOP_W = 8;

    // configuration registers
    localparam int FWD_LIMIT_W  = 8;
    localparam int SEND_LIMIT_W = 7;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [FWD_LIMIT_W-1:0]  FWD_LIMIT_RESET  = 8'd12;
    localparam logic [SEND_LIMIT_W-1:0] SEND_LIMIT_RESET = 7'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FWD_LIMIT  = 1'b0,
        REG_SEND_LIMIT = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

### design/gltm_ram.sv
// ----------------------------------------------------------------------------
// gltm_ram
// Simple dual-port synchronous memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gltm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 38
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/gossip_load_table_merge.sv
// ----------------------------------------------------------------------------
// gossip_load_table_merge
// Keeps a node-id sorted table of (id, load) entries, merges incoming gossip
// runs into it and forwards the head of the merged table.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one (id, load) entry per transfer, tuser holds the
//   hop count and tlast ends a message. Entries load at one per cycle into an
//   incoming buffer memory. At the tlast transfer the input stalls while the
//   buffer is merged with the table; each merge step (a pair of equal ids is
//   one step) reads the table and buffer memories (S_MRG_RD), then compares
//   and writes the merged entry (S_MRG_CMP). The merge writes the other half
//   of a two-bank table memory, then the banks swap.
//   If forwarding is allowed, the first entries of the new table go out on
//   the output stream, tagged with hop + 1 (saturating), tlast on the final
//   one. Each entry is read (S_FWD_RD), then loaded for output (S_FWD_LD).
//   A held output register stalls the forward walk; once the final entry sits
//   in the output register, new input is accepted again.
//   Reset empties the table and the buffer and restores the register
//   defaults (forward limit 12, send limit 0); no clearing pass is needed.
//   Configuration writes are taken in any cycle; each forward check uses them.
// ----------------------------------------------------------------------------
`default_nettype none

module gossip_load_table_merge
    import gltm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int LOAD_WIDTH  = LOAD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wr_data,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: node_id, node_load, zero pad
    input  wire logic [((ID_W+LOAD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: hop_in
    input  wire logic [HOP_W-1:0]       i_s_axis_tuser,
    input  wire logic                   i_s_axis_tlast,
    // output stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: out_node_id, out_node_load, zero pad
    output logic      [((ID_W+LOAD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: hop_out
    output logic      [HOP_W-1:0]       o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int EW    = ID_W + LOAD_WIDTH;
    localparam int CMPW  = CW + SEND_LIMIT_W;
    localparam int TBL_DEPTH_RAM = 2 * (2 ** AW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MRG_RD,
        S_MRG_CMP,
        S_FWD_CHK,
        S_FWD_RD,
        S_FWD_LD
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_bank, n_bank;
    logic [CW-1:0]           r_tcnt, n_tcnt;
    logic [CW-1:0]           r_icnt, n_icnt;
    logic [CW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_j, n_j;
    logic [CW-1:0]           r_k, n_k;
    logic [CW-1:0]           r_send, n_send;
    logic [FWD_LIMIT_W-1:0]  r_fwd_cnt, n_fwd_cnt;
    logic [HOP_W-1:0]        r_hop, n_hop;
    logic [FWD_LIMIT_W-1:0]  r_fwd_limit, n_fwd_limit;
    logic [SEND_LIMIT_W-1:0] r_send_limit, n_send_limit;
    logic                    r_out_valid, n_out_valid;
    logic [ID_W-1:0]         r_out_id, n_out_id;
    logic [LOAD_WIDTH-1:0]   r_out_load, n_out_load;
    logic [HOP_W-1:0]        r_out_hop, n_out_hop;
    logic                    r_out_last, n_out_last;

    // memory ports
    logic          inc_we, inc_re;
    logic [AW-1:0] inc_waddr, inc_raddr;
    logic [EW-1:0] inc_wdata, inc_rdata;
    logic          tbl_we, tbl_re;
    logic [AW:0]   tbl_waddr, tbl_raddr;
    logic [EW-1:0] tbl_wdata, tbl_rdata;

    // merge compare
    logic [ID_W-1:0]       t_id, c_id;
    logic                  has_t, has_c, take_t, ids_eq;
    logic                  in_xfer, out_load;
    logic [CMPW-1:0]       lim_ext, tcnt_ext;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    assign t_id   = tbl_rdata[ID_W-1:0];
    assign c_id   = inc_rdata[ID_W-1:0];
    assign has_t  = r_i < r_tcnt;
    assign has_c  = r_j < r_icnt;
    assign ids_eq = t_id == c_id;
    assign take_t = has_t && (!has_c || (t_id < c_id));

    assign lim_ext  = CMPW'(r_send_limit);
    assign tcnt_ext = CMPW'(r_tcnt);

    // incoming buffer: filled from the input stream, read by the merge
    assign inc_we    = in_xfer && (r_icnt < CW'(TABLE_DEPTH));
    assign inc_waddr = r_icnt[AW-1:0];
    assign inc_wdata = i_s_axis_tdata[EW-1:0];
    assign inc_re    = r_state == S_MRG_RD;
    assign inc_raddr = r_j[AW-1:0];

    // table: merge reads the live bank and writes the other one
    assign tbl_we    = (r_state == S_MRG_CMP) && (r_k < CW'(TABLE_DEPTH));
    assign tbl_waddr = {~r_bank, r_k[AW-1:0]};
    assign tbl_wdata = take_t ? tbl_rdata : inc_rdata;
    assign tbl_re    = (r_state == S_MRG_RD) || (r_state == S_FWD_RD);
    assign tbl_raddr = (r_state == S_FWD_RD) ? {r_bank, r_k[AW-1:0]}
                                             : {r_bank, r_i[AW-1:0]};

    gltm_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW)
    ) u_inc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (inc_we),
        .i_wr_addr (inc_waddr),
        .i_wr_data (inc_wdata),
        .i_rd_en   (inc_re),
        .i_rd_addr (inc_raddr),
        .o_rd_data (inc_rdata)
    );

    gltm_ram #(
        .DEPTH (TBL_DEPTH_RAM),
        .WIDTH (EW)
    ) u_tbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_waddr),
        .i_wr_data (tbl_wdata),
        .i_rd_en   (tbl_re),
        .i_rd_addr (tbl_raddr),
        .o_rd_data (tbl_rdata)
    );

    // output register is free or being emptied this cycle
    assign out_load = (r_state == S_FWD_LD) && (!r_out_valid || i_m_axis_tready);

    // next state and next register values
    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_tcnt       = r_tcnt;
        n_icnt       = r_icnt;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_send       = r_send;
        n_fwd_cnt    = r_fwd_cnt;
        n_hop        = r_hop;
        n_fwd_limit  = r_fwd_limit;
        n_send_limit = r_send_limit;
        n_out_valid  = r_out_valid;
        n_out_id     = r_out_id;
        n_out_load   = r_out_load;
        n_out_hop    = r_out_hop;
        n_out_last   = r_out_last;

        // configuration writes
        if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FWD_LIMIT:  n_fwd_limit  = i_cfg_wr_data;
                REG_SEND_LIMIT: n_send_limit = i_cfg_wr_data[SEND_LIMIT_W-1:0];
                default: ;
            endcase
        end

        // output register drains on a transfer
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (inc_we) begin
                        n_icnt = r_icnt + 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_hop   = (i_s_axis_tuser == '1) ? i_s_axis_tuser
                                                         : i_s_axis_tuser + 1'b1;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_MRG_RD;
                    end
                end
            end
            S_MRG_RD: begin
                if (has_t || has_c) begin
                    n_state = S_MRG_CMP;
                end else begin
                    // merge done, swap banks
                    n_bank  = ~r_bank;
                    n_tcnt  = r_k;
                    n_icnt  = '0;
                    n_state = S_FWD_CHK;
                end
            end
            S_MRG_CMP: begin
                if (take_t || (has_t && has_c && ids_eq)) begin
                    n_i = r_i + 1'b1;
                end
                if (!take_t) begin
                    n_j = r_j + 1'b1;
                end
                if (tbl_we) begin
                    n_k = r_k + 1'b1;
                end
                n_state = S_MRG_RD;
            end
            S_FWD_CHK: begin
                if (r_fwd_cnt > r_fwd_limit) begin
                    n_state = S_IDLE;
                end else begin
                    if ((r_send_limit != '0) && (lim_ext < tcnt_ext)) begin
                        n_send = CW'(r_send_limit);
                    end else begin
                        n_send = r_tcnt;
                    end
                    if (r_fwd_cnt != '1) begin
                        n_fwd_cnt = r_fwd_cnt + 1'b1;
                    end
                    n_k     = '0;
                    n_state = (n_send == '0) ? S_IDLE : S_FWD_RD;
                end
            end
            S_FWD_RD: begin
                n_state = S_FWD_LD;
            end
            S_FWD_LD: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_id    = tbl_rdata[ID_W-1:0];
                    n_out_load  = tbl_rdata[EW-1:ID_W];
                    n_out_hop   = r_hop;
                    n_out_last  = CW'(r_k + 1'b1) == r_send;
                    n_k         = r_k + 1'b1;
                    n_state     = (CW'(r_k + 1'b1) == r_send) ? S_IDLE : S_FWD_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bank       <= 1'b0;
            r_tcnt       <= '0;
            r_icnt       <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_send       <= '0;
            r_fwd_cnt    <= '0;
            r_hop        <= '0;
            r_fwd_limit  <= FWD_LIMIT_RESET;
            r_send_limit <= SEND_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bank       <= n_bank;
            r_tcnt       <= n_tcnt;
            r_icnt       <= n_icnt;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
            r_send       <= n_send;
            r_fwd_cnt    <= n_fwd_cnt;
            r_hop        <= n_hop;
            r_fwd_limit  <= n_fwd_limit;
            r_send_limit <= n_send_limit;
            r_out_valid  <= n_out_valid;
        end
        r_out_id   <= n_out_id;
        r_out_load <= n_out_load;
        r_out_hop  <= n_out_hop;
        r_out_last <= n_out_last;
    end

    // port drive
    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hop;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        o_m_axis_tdata              = '0;
        o_m_axis_tdata[ID_W-1:0]    = r_out_id;
        o_m_axis_tdata[EW-1:ID_W]   = r_out_load;
    end

`ifndef SYNTHESIS
    // table and buffer never hold more than the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tcnt <= CW'(TABLE_DEPTH)) && (r_icnt <= CW'(TABLE_DEPTH)))
        else $error("entry count above table depth");

    // merge write index never exceeds the table depth
    a_merge_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_CMP) |-> (r_k <= CW'(TABLE_DEPTH)))
        else $error("merge index out of range");

    // forward walk stays below the send count
    a_fwd_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FWD_RD) || (r_state == S_FWD_LD)) |-> (r_k < r_send))
        else $error("forward index past send count");

    // forward counter never goes down
    a_fwd_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_cnt >= $past(r_fwd_cnt))
        else $error("forward counter decreased");
`endif

endmodule

`default_nettype wire

### tb/tb_gossip_load_table_merge.sv
// ----------------------------------------------------------------------------
// tb_gossip_load_table_merge
// Self-checking bench for the gossip load table merge block. Messages of
// (id, load) transfers go in on the input stream. A predictor keeps its own
// sorted table and forward counter and queues the entries that each message
// end should forward. The output stream is compared field by field against
// that queue, under several register settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gossip_load_table_merge;
    import gltm_pkg::*;

    localparam int TBL        = TABLE_DEPTH_DEF;
    localparam int LW         = LOAD_WIDTH_DEF;
    localparam int DATA_W     = ((ID_W + LW + 7) / 8) * 8;
    localparam int SETTLE_CYC = 4 * TBL + 2 * TBL + 200;
    localparam int DRAIN_CYC  = 20000;
    localparam int CYCLE_CAP  = 1500000;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LW-1:0]    load;
        logic [HOP_W-1:0] hop;
        logic             last;
    } t_gossip_item;

    // dut ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata: node_id, node_load, zero pad
    logic [DATA_W-1:0]      i_s_axis_tdata = '0;
    // tuser: hop_in
    logic [HOP_W-1:0]       i_s_axis_tuser = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata: out_node_id, out_node_load, zero pad
    logic [DATA_W-1:0]      o_m_axis_tdata;
    // tuser: hop_out
    logic [HOP_W-1:0]       o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    gossip_load_table_merge u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // stimulus and expectation stores
    t_gossip_item pending_q[$];
    t_gossip_item fwd_expect_q[$];
    t_gossip_item drv_item;
    t_gossip_item got_item;
    t_gossip_item exp_item;

    // predictor state
    logic [ID_W-1:0] tbl_ids[TBL];
    logic [LW-1:0]   tbl_loads[TBL];
    int              tbl_cnt = 0;
    logic [ID_W-1:0] run_ids[TBL];
    logic [LW-1:0]   run_loads[TBL];
    int              run_cnt = 0;
    int              fwd_cnt = 0;
    int              fwd_limit = FWD_LIMIT_RESET;
    int              send_limit = SEND_LIMIT_RESET;

    // run control and statistics
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;
    int n_in = 0;
    int n_msgs = 0;
    int n_checked = 0;
    int n_suppressed = 0;
    int max_run = 0;
    int max_tbl = 0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        err_cnt++;
        $display("ERROR @%0d: %s", cycle_cnt, msg);
    endtask

    // merge one message run into the table and queue what gets forwarded
    function automatic void merge_and_forward(t_gossip_item it);
        logic [ID_W-1:0] m_ids[TBL];
        logic [LW-1:0]   m_loads[TBL];
        int i, j, k, n_out;
        logic [HOP_W-1:0] hop_next;
        t_gossip_item e;
        i = 0;
        j = 0;
        k = 0;
        if (run_cnt < TBL) begin
            run_ids[run_cnt]   = it.id;
            run_loads[run_cnt] = it.load;
            run_cnt++;
        end
        if (!it.last) return;
        n_msgs++;
        if (run_cnt > max_run) max_run = run_cnt;
        // sorted merge, incoming load wins on equal ids
        while (i < tbl_cnt && j < run_cnt) begin
            if (tbl_ids[i] < run_ids[j]) begin
                if (k < TBL) begin
                    m_ids[k] = tbl_ids[i];
                    m_loads[k] = tbl_loads[i];
                    k++;
                end
                i++;
            end else begin
                if (k < TBL) begin
                    m_ids[k] = run_ids[j];
                    m_loads[k] = run_loads[j];
                    k++;
                end
                if (tbl_ids[i] == run_ids[j]) i++;
                j++;
            end
        end
        // tails: rest of the run first, then rest of the table
        while (j < run_cnt) begin
            if (k < TBL) begin
                m_ids[k] = run_ids[j];
                m_loads[k] = run_loads[j];
                k++;
            end
            j++;
        end
        while (i < tbl_cnt) begin
            if (k < TBL) begin
                m_ids[k] = tbl_ids[i];
                m_loads[k] = tbl_loads[i];
                k++;
            end
            i++;
        end
        for (i = 0; i < k; i++) begin
            tbl_ids[i] = m_ids[i];
            tbl_loads[i] = m_loads[i];
        end
        tbl_cnt = k;
        if (tbl_cnt > max_tbl) max_tbl = tbl_cnt;
        run_cnt = 0;
        hop_next = (it.hop == '1) ? it.hop : it.hop + 1'b1;
        // forward only while the counter is within its limit
        if (fwd_cnt > fwd_limit) begin
            n_suppressed++;
            return;
        end
        n_out = tbl_cnt;
        if (send_limit != 0 && send_limit < n_out) n_out = send_limit;
        for (i = 0; i < n_out; i++) begin
            e.id = tbl_ids[i];
            e.load = tbl_loads[i];
            e.hop = hop_next;
            e.last = (i == n_out - 1);
            fwd_expect_q.insert(fwd_expect_q.size(), e);
        end
        if (fwd_cnt < 255) fwd_cnt++;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                drv_item = pending_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(DATA_W - ID_W - LW){1'b0}}, drv_item.load, drv_item.id};
                i_s_axis_tuser  <= drv_item.hop;
                i_s_axis_tlast  <= drv_item.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // monitor: check output transfers, predict from input transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_item.id   = o_m_axis_tdata[ID_W-1:0];
                got_item.load = o_m_axis_tdata[ID_W+LW-1:ID_W];
                got_item.hop  = o_m_axis_tuser;
                got_item.last = o_m_axis_tlast;
                if (fwd_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output transfer id %0d",
                                              got_item.id));
                end else begin
                    exp_item = fwd_expect_q.pop_front();
                    n_checked++;
                    if (got_item.id != exp_item.id)
                        report_mismatch($sformatf("node id got 0x%0h expected 0x%0h",
                                                  got_item.id, exp_item.id));
                    if (got_item.load != exp_item.load)
                        report_mismatch($sformatf("node load got 0x%0h expected 0x%0h",
                                                  got_item.load, exp_item.load));
                    if (got_item.hop != exp_item.hop)
                        report_mismatch($sformatf("hop got 0x%0h expected 0x%0h",
                                                  got_item.hop, exp_item.hop));
                    if (got_item.last != exp_item.last)
                        report_mismatch($sformatf("tlast got %0d expected %0d",
                                                  got_item.last, exp_item.last));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                n_in++;
                merge_and_forward('{id: i_s_axis_tdata[ID_W-1:0],
                                    load: i_s_axis_tdata[ID_W+LW-1:ID_W],
                                    hop: i_s_axis_tuser, last: i_s_axis_tlast});
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("gossip_load_table_merge verification failed");
            $finish;
        end
    end

    task automatic push_item(int id, logic [LW-1:0] load, int hop, bit last);
        pending_q.insert(pending_q.size(),
                         '{id: id[ID_W-1:0], load: load, hop: hop[HOP_W-1:0], last: last});
    endtask

    task automatic write_reg(t_cfg_reg idx, int val);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_FWD_LIMIT:  fwd_limit = val & 8'hFF;
            REG_SEND_LIMIT: send_limit = val & 7'h7F;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [LW-1:0] pick_load();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // queue random messages until about n items are pending
    task automatic queue_messages(int n);
        int added, len, r, hop, cnt, id;
        bit [TBL-1:0] used;
        added = 0;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 8);
            else if (r < 90) len = $urandom_range(9, 40);
            else if (r < 97) len = $urandom_range(41, TBL);
            else len = $urandom_range(TBL + 1, TBL + 8);
            r = $urandom_range(0, 9);
            hop = (r == 0) ? 255 : (r == 1) ? 254 : (r == 2) ? 0 : $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 80 && len <= TBL) begin
                // well-formed: distinct ascending ids, one hop count
                used = '0;
                cnt = 0;
                while (cnt < len) begin
                    id = $urandom_range(0, TBL - 1);
                    if (!used[id]) begin
                        used[id] = 1'b1;
                        cnt++;
                    end
                end
                cnt = 0;
                for (id = 0; id < TBL; id++) begin
                    if (used[id]) begin
                        cnt++;
                        push_item(id, pick_load(), hop, cnt == len);
                    end
                end
            end else begin
                // noise: any id order, hop varies per transfer
                for (cnt = 1; cnt <= len; cnt++)
                    push_item($urandom_range(0, TBL - 1), pick_load(),
                              (cnt == len) ? hop : $urandom_range(0, 255), cnt == len);
            end
            added += len;
        end
    endtask

    // wait for all stimulus to go in and all forwards to come out
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (pending_q.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (fwd_expect_q.size() != 0 && waited < DRAIN_CYC) begin
            @(posedge i_clk);
            waited++;
        end
        if (fwd_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected forwards never arrived",
                                      fwd_expect_q.size()));
            fwd_expect_q.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // test sequence
    initial begin
        int k, lim;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 23;
        rcv_idle_pct = 52;

        // directed messages under the reset register values
        push_item(0, '0, 0, 1);
        push_item(63, '1, 255, 1);
        push_item(1, 32'h0001_0000, 254, 0);
        push_item(5, 32'h8000_0000, 254, 0);
        push_item(63, 32'h1234_5678, 254, 1);
        push_item(10, 32'hAAAA_AAAA, 7, 0);
        push_item(3, 32'h5555_5555, 7, 0);
        push_item(3, 32'h0000_FFFF, 7, 1);
        push_item(42, 32'h5555_5555, 8'hAA, 0);
        push_item(21, 32'hAAAA_AAAA, 8'h55, 1);
        push_item(0, 32'h0000_0001, 128, 1);
        wait_idle();

        // whole table forwarded, no forward limit
        write_reg(REG_FWD_LIMIT, 255);
        write_reg(REG_SEND_LIMIT, 0);
        queue_messages(50);
        wait_idle();

        write_reg(REG_SEND_LIMIT, 1);
        queue_messages(20);
        wait_idle();

        snd_idle_pct = 52;
        rcv_idle_pct = 23;

        // forward limit crossed in the middle of the phase
        lim = (fwd_cnt + 3 > 255) ? 255 : fwd_cnt + 3;
        write_reg(REG_SEND_LIMIT, TBL);
        write_reg(REG_FWD_LIMIT, lim);
        queue_messages(40);
        wait_idle();

        // nothing forwarded
        write_reg(REG_FWD_LIMIT, 0);
        write_reg(REG_SEND_LIMIT, 5);
        queue_messages(15);
        wait_idle();

        // drive the forward counter into saturation, then just under it
        write_reg(REG_FWD_LIMIT, 255);
        write_reg(REG_SEND_LIMIT, 1);
        lim = 260 - fwd_cnt;
        for (k = 0; k < lim; k++)
            push_item($urandom_range(0, TBL - 1), pick_load(), $urandom_range(0, 255), 1);
        wait_idle();
        write_reg(REG_FWD_LIMIT, 254);
        queue_messages(10);
        wait_idle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;

        write_reg(REG_FWD_LIMIT, 255);
        write_reg(REG_SEND_LIMIT, $urandom_range(2, TBL - 1));
        queue_messages(35);
        wait_idle();

        write_reg(REG_SEND_LIMIT, 0);
        queue_messages(35);
        wait_idle();

        $display("covered %0d input transfers in %0d messages, %0d forwarded entries checked",
                 n_in, n_msgs, n_checked);
        $display("forwards held back by the limit: %0d, longest run %0d, fullest table %0d",
                 n_suppressed, max_run, max_tbl);
        if (err_cnt == 0) begin
            $display("gossip_load_table_merge verification clean");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("gossip_load_table_merge verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
